// File: rtl/hrcp_pkg.sv
// ----------------------------------------------------------------------------
// hrcp_pkg: shared types and constants
// phase codes, fail causes, chunk phases, match strings, the queue entry and the result for the chunked decoder
// ----------------------------------------------------------------------------
package hrcp_pkg;

  localparam logic [2:0] PH_STATUS  = 3'd0;
  localparam logic [2:0] PH_HEADERS = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_FAILED  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [2:0] FC_NONE     = 3'd0;
  localparam logic [2:0] FC_STATUS   = 3'd1;
  localparam logic [2:0] FC_NO_COLON = 3'd2;
  localparam logic [2:0] FC_ENCODING = 3'd3;
  localparam logic [2:0] FC_CHUNK    = 3'd4;
  localparam logic [2:0] FC_EARLY    = 3'd5;

  localparam logic [1:0] CK_LENGTH  = 2'd0;
  localparam logic [1:0] CK_PAYLOAD = 2'd1;
  localparam logic [1:0] CK_TRAILER = 2'd2;

  localparam int unsigned KeyLen = 17;
  localparam int unsigned ValLen = 7;
  localparam int unsigned OkLen  = 6;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] content;
    logic       valid;
    logic [2:0] phase;
    logic [2:0] cause;
  } result_t;

  function automatic logic [7:0] ok_char(input logic [2:0] idx);
    case (idx)
      3'd0: ok_char = 8'h32;
      3'd1: ok_char = 8'h30;
      3'd2: ok_char = 8'h30;
      3'd3: ok_char = 8'h20;
      3'd4: ok_char = 8'h4f;
      3'd5: ok_char = 8'h4b;
      default: ok_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [4:0] idx);
    case (idx)
      5'd0: key_char = "t";
      5'd1: key_char = "r";
      5'd2: key_char = "a";
      5'd3: key_char = "n";
      5'd4: key_char = "s";
      5'd5: key_char = "f";
      5'd6: key_char = "e";
      5'd7: key_char = "r";
      5'd8: key_char = "-";
      5'd9: key_char = "e";
      5'd10: key_char = "n";
      5'd11: key_char = "c";
      5'd12: key_char = "o";
      5'd13: key_char = "d";
      5'd14: key_char = "i";
      5'd15: key_char = "n";
      5'd16: key_char = "g";
      default: key_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] val_char(input logic [2:0] idx);
    case (idx)
      3'd0: val_char = "c";
      3'd1: val_char = "h";
      3'd2: val_char = "u";
      3'd3: val_char = "n";
      3'd4: val_char = "k";
      3'd5: val_char = "e";
      3'd6: val_char = "d";
      default: val_char = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/hrcp_front.sv
// ----------------------------------------------------------------------------
// hrcp_front: input stage
// takes input transfers into a two-entry queue toward the decoder
// ----------------------------------------------------------------------------
module hrcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hrcp_pkg::item_t in_item_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output hrcp_pkg::item_t q_item_o
);

  hrcp_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: rtl/hrcp_back.sv
// ----------------------------------------------------------------------------
// hrcp_back: protocol decoder
// per-byte status, header and chunk state update with a registered result
// ----------------------------------------------------------------------------
module hrcp_back #(
  parameter int unsigned CHUNK_LEN_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  hrcp_pkg::item_t   q_item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output hrcp_pkg::result_t res_o
);

  logic [2:0] phase_q, phase_d;
  logic       pcr_q, pcr_d;
  logic [2:0] smp_q, smp_d;
  logic       sok_q, sok_d;
  logic       le_q, le_d;
  logic       inv_q, inv_d;
  logic [4:0] kmp_q, kmp_d;
  logic       kmm_q, kmm_d;
  logic [2:0] vmp_q, vmp_d;
  logic       vmm_q, vmm_d;
  logic       tss_q, tss_d;
  logic       chm_q, chm_d;
  logic [1:0] ckp_q, ckp_d;
  logic [CHUNK_LEN_BITS-1:0] rem_q, rem_d;
  logic       hdc_q, hdc_d;
  logic       trc_q, trc_d;
  logic       lch_q, lch_d;
  logic [2:0] cause_q, cause_d;
  logic       rv_q;
  hrcp_pkg::result_t res_q, res_d;
  logic       take, valid;
  logic [7:0] b;

  assign q_ready_o   = !rv_q || res_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
  assign b           = q_item_i.data;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= "9") hex_val = 4'(c - "0");
    else if (c >= "a") hex_val = 4'(c - "a" + 8'd10);
    else hex_val = 4'(c - "A" + 8'd10);
  endfunction

  always_comb begin
    logic       fire_line_end;
    logic [1:0] nchars;
    logic [7:0] c;
    logic [7:0] lc;
    fire_line_end = 1'b0;
    nchars = 2'd0;
    c = 8'h0d;
    lc = 8'h0d;
    phase_d = phase_q; pcr_d = pcr_q; smp_d = smp_q; sok_d = sok_q;
    le_d = le_q; inv_d = inv_q; kmp_d = kmp_q; kmm_d = kmm_q;
    vmp_d = vmp_q; vmm_d = vmm_q; tss_d = tss_q; chm_d = chm_q;
    ckp_d = ckp_q; rem_d = rem_q; hdc_d = hdc_q; trc_d = trc_q;
    lch_d = lch_q; cause_d = cause_q; valid = 1'b0;

    if (phase_q == hrcp_pkg::PH_STATUS || phase_q == hrcp_pkg::PH_HEADERS) begin
      if (q_item_i.eos) begin
        phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_EARLY; pcr_d = 1'b0;
      end else if (pcr_q) begin
        if (b == 8'h0a) begin
          pcr_d = 1'b0; fire_line_end = 1'b1;
        end else if (b == 8'h0d) begin
          nchars = 2'd1;
        end else begin
          pcr_d = 1'b0; nchars = 2'd2;
        end
      end else if (b == 8'h0d) begin
        pcr_d = 1'b1;
      end else begin
        nchars = 2'd3;
      end
    end

    // up to two line characters: a held CR then the byte
    for (int k = 0; k < 2; k++) begin
      c = 8'h0d;
      if (k == 1 || nchars == 2'd3) c = b;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if ((k == 0 && nchars != 2'd0) || (k == 1 && nchars == 2'd2)) begin
        if (phase_q == hrcp_pkg::PH_STATUS) begin
          if (!sok_d) begin
            if (smp_d < 3'(hrcp_pkg::OkLen) && c == hrcp_pkg::ok_char(smp_d))
              smp_d = smp_d + 3'd1;
            else
              smp_d = (c == "2") ? 3'd1 : 3'd0;
            if (smp_d >= 3'(hrcp_pkg::OkLen)) sok_d = 1'b1;
          end
        end else begin
          le_d = 1'b0;
          if (!inv_d && c == ":") begin
            inv_d = 1'b1; tss_d = 1'b0; vmp_d = 3'd0; vmm_d = 1'b0;
          end else if (c == " " || c == 8'h09) begin
            if (!inv_d) begin
              if (kmp_d != 5'd0 || kmm_d) tss_d = 1'b1;
            end else if (vmp_d != 3'd0 || vmm_d) tss_d = 1'b1;
          end else if (!inv_d) begin
            if (!tss_d && kmp_d < 5'(hrcp_pkg::KeyLen) && lc == hrcp_pkg::key_char(kmp_d))
              kmp_d = kmp_d + 5'd1;
            else kmm_d = 1'b1;
          end else begin
            if (!tss_d && vmp_d < 3'(hrcp_pkg::ValLen) && lc == hrcp_pkg::val_char(vmp_d))
              vmp_d = vmp_d + 3'd1;
            else vmm_d = 1'b1;
          end
        end
      end
    end

    if (fire_line_end) begin
      if (phase_q == hrcp_pkg::PH_STATUS) begin
        if (sok_q) begin
          phase_d = hrcp_pkg::PH_HEADERS;
          le_d = 1'b1; inv_d = 1'b0; kmp_d = 5'd0; kmm_d = 1'b0;
          vmp_d = 3'd0; vmm_d = 1'b0; tss_d = 1'b0;
        end else begin
          phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_STATUS;
        end
      end else if (le_q) begin
        phase_d = hrcp_pkg::PH_BODY;
        ckp_d = hrcp_pkg::CK_LENGTH; rem_d = '0; hdc_d = 1'b0; trc_d = 1'b0;
        lch_d = 1'b0;
      end else if (!inv_q) begin
        phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_NO_COLON;
      end else if (!kmm_q && kmp_q == 5'(hrcp_pkg::KeyLen) &&
                   !(!vmm_q && vmp_q == 3'(hrcp_pkg::ValLen))) begin
        phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_ENCODING;
      end else begin
        if (!kmm_q && kmp_q == 5'(hrcp_pkg::KeyLen)) chm_d = 1'b1;
        le_d = 1'b1; inv_d = 1'b0; kmp_d = 5'd0; kmm_d = 1'b0;
        vmp_d = 3'd0; vmm_d = 1'b0; tss_d = 1'b0;
      end
    end

    if (phase_q == hrcp_pkg::PH_BODY) begin
      if (!chm_q) begin
        if (q_item_i.eos) phase_d = hrcp_pkg::PH_DONE;
        else valid = 1'b1;
      end else if (q_item_i.eos) begin
        phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_EARLY; pcr_d = 1'b0;
      end else if (ckp_q == hrcp_pkg::CK_PAYLOAD) begin
        valid = 1'b1;
        rem_d = rem_q - CHUNK_LEN_BITS'(1);
        if (rem_d == '0) begin
          ckp_d = hrcp_pkg::CK_TRAILER; trc_d = 1'b0;
        end
      end else if (ckp_q == hrcp_pkg::CK_TRAILER) begin
        trc_d = 1'b1;
        if (trc_q) begin
          if (lch_q) begin
            phase_d = hrcp_pkg::PH_DONE; trc_d = 1'b0;
          end else begin
            ckp_d = hrcp_pkg::CK_LENGTH; rem_d = '0; hdc_d = 1'b0;
            trc_d = 1'b0; pcr_d = 1'b0;
          end
        end
      end else if (pcr_q) begin
        pcr_d = 1'b0;
        if (b != 8'h0a || !hdc_q) begin
          phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_CHUNK;
        end else begin
          if (rem_q == '0) begin
            lch_d = 1'b1; ckp_d = hrcp_pkg::CK_TRAILER;
          end else ckp_d = hrcp_pkg::CK_PAYLOAD;
          trc_d = 1'b0;
        end
      end else if (b == 8'h0d) begin
        pcr_d = 1'b1;
      end else if (!is_hex(b) || rem_q[CHUNK_LEN_BITS-1 -: 4] != 4'd0) begin
        phase_d = hrcp_pkg::PH_FAILED; cause_d = hrcp_pkg::FC_CHUNK;
      end else begin
        rem_d = {rem_q[CHUNK_LEN_BITS-5:0], hex_val(b)};
        hdc_d = 1'b1;
      end
    end

    res_d.content = valid ? b : 8'h00;
    res_d.valid   = valid;
    res_d.phase   = phase_d;
    res_d.cause   = (phase_d == hrcp_pkg::PH_FAILED) ? cause_d : hrcp_pkg::FC_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrcp_pkg::PH_STATUS; pcr_q <= 1'b0; smp_q <= 3'd0; sok_q <= 1'b0;
      le_q <= 1'b1; inv_q <= 1'b0; kmp_q <= 5'd0; kmm_q <= 1'b0;
      vmp_q <= 3'd0; vmm_q <= 1'b0; tss_q <= 1'b0; chm_q <= 1'b0;
      ckp_q <= hrcp_pkg::CK_LENGTH; rem_q <= '0; hdc_q <= 1'b0; trc_q <= 1'b0;
      lch_q <= 1'b0; cause_q <= hrcp_pkg::FC_NONE; rv_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; pcr_q <= pcr_d; smp_q <= smp_d; sok_q <= sok_d;
        le_q <= le_d; inv_q <= inv_d; kmp_q <= kmp_d; kmm_q <= kmm_d;
        vmp_q <= vmp_d; vmm_q <= vmm_d; tss_q <= tss_d; chm_q <= chm_d;
        ckp_q <= ckp_d; rem_q <= rem_d; hdc_q <= hdc_d; trc_q <= trc_d;
        lch_q <= lch_d; cause_q <= cause_d;
      end
      if (q_ready_o) rv_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

endmodule

// File: rtl/http_response_chunked_parser.sv
// ----------------------------------------------------------------------------
// http_response_chunked_parser: chunked http response decoder
// status check, header scan and chunked or identity body pass-through
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_axis    in   data_byte[7:0]                          command
// m_axis    out  content_byte[7:0], phase_now[10:8],     content_valid
//                fail_cause[13:11], zero pad [15:14]
// one transfer per cycle sustained while the output is not stalled; a result is registered
// after its input transfer in the queue stage, then in the decoder result register
// all per-byte state updates are combinational in the decoder
// reset clears all control state; each side may stall independently
// ----------------------------------------------------------------------------
module http_response_chunked_parser #(
  parameter int unsigned CHUNK_LEN_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // content_byte, phase_now, fail_cause, pad
  output logic        m_axis_tuser    // content_valid
);

  hrcp_pkg::item_t   in_item, q_item;
  hrcp_pkg::result_t res;
  logic              q_valid, q_ready;

  assign in_item.eos  = s_axis_tuser;
  assign in_item.data = s_axis_tdata;

  hrcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  hrcp_back #(.CHUNK_LEN_BITS(CHUNK_LEN_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.cause, res.phase, res.content};
  assign m_axis_tuser = res.valid;

endmodule

// File: dv/tb_http_response_chunked_parser.sv
// ----------------------------------------------------------------------------
// tb_http_response_chunked_parser: self-checking stream testbench
// feeds one long chunked response (status line, headers, random chunks, a
// random ending) and then ignored events, predicts every result transfer in
// a local decoder model and compares all fields under random idling and stall
// ----------------------------------------------------------------------------
module tb_http_response_chunked_parser;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // content_byte, phase_now, fail_cause, pad
  logic        m_axis_tuser;        // content_valid

  http_response_chunked_parser uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #2 clk_i = ~clk_i;

  hrcp_pkg::item_t   byte_q[$];
  hrcp_pkg::result_t want_q[$];
  int      sent_cnt, got_cnt, content_cnt, err_cnt, cyc_cnt, hold_cnt;
  bit      hold_done;

  // decoder state
  logic [2:0]  ph;
  bit          pend_cr, ok_seen, ln_empty, in_val, key_bad, val_bad, trail_sp;
  bit          chunked, last_ck;
  int unsigned st_pos, key_pos, val_pos, hex_cnt, trl_cnt;
  logic [1:0]  ck_ph;
  logic [31:0] remain;
  logic [2:0]  cause;
  string       ok_pat = "200 OK";
  string       key_pat = "transfer-encoding";
  string       val_pat = "chunked";

  function automatic void set_fail(logic [2:0] c);
    ph = hrcp_pkg::PH_FAILED;
    cause = c;
    pend_cr = 0;
  endfunction

  function automatic void clear_line();
    ln_empty = 1; in_val = 0; key_pos = 0; key_bad = 0;
    val_pos = 0; val_bad = 0; trail_sp = 0;
  endfunction

  function automatic void clear_length();
    ck_ph = hrcp_pkg::CK_LENGTH; remain = '0; hex_cnt = 0; trl_cnt = 0; pend_cr = 0;
  endfunction

  function automatic void match_step(input byte unsigned c, input string pat,
                                     inout int unsigned pos, inout bit bad);
    byte unsigned lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (c == " " || c == "\t") begin
      if (pos != 0 || bad) trail_sp = 1;
    end else if (trail_sp) begin
      bad = 1;
    end else if (pos < pat.len() && lc == pat[pos]) begin
      pos++;
    end else begin
      bad = 1;
    end
  endfunction

  function automatic void line_byte(byte unsigned c);
    if (ph == hrcp_pkg::PH_STATUS) begin
      if (!ok_seen) begin
        if (st_pos < hrcp_pkg::OkLen && c == ok_pat[st_pos]) st_pos++;
        else st_pos = (c == "2") ? 1 : 0;
        if (st_pos >= hrcp_pkg::OkLen) ok_seen = 1;
      end
    end else begin
      ln_empty = 0;
      if (!in_val && c == ":") begin
        in_val = 1; trail_sp = 0; val_pos = 0; val_bad = 0;
      end else if (!in_val) begin
        match_step(c, key_pat, key_pos, key_bad);
      end else begin
        match_step(c, val_pat, val_pos, val_bad);
      end
    end
  endfunction

  function automatic void end_of_line();
    if (ph == hrcp_pkg::PH_STATUS) begin
      if (ok_seen) begin
        ph = hrcp_pkg::PH_HEADERS;
        clear_line();
      end else begin
        set_fail(hrcp_pkg::FC_STATUS);
      end
    end else if (ln_empty) begin
      ph = hrcp_pkg::PH_BODY;
      clear_length();
      last_ck = 0;
    end else if (!in_val) begin
      set_fail(hrcp_pkg::FC_NO_COLON);
    end else if (!key_bad && key_pos == hrcp_pkg::KeyLen &&
                 !(!val_bad && val_pos == hrcp_pkg::ValLen)) begin
      set_fail(hrcp_pkg::FC_ENCODING);
    end else begin
      if (!key_bad && key_pos == hrcp_pkg::KeyLen) chunked = 1;
      clear_line();
    end
  endfunction

  function automatic int hex_of(byte unsigned b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function automatic bit body_byte(byte unsigned b);
    int v;
    if (ck_ph == hrcp_pkg::CK_PAYLOAD) begin
      remain = remain - 1;
      if (remain == 0) begin
        ck_ph = hrcp_pkg::CK_TRAILER; trl_cnt = 0;
      end
      return 1;
    end
    if (ck_ph == hrcp_pkg::CK_TRAILER) begin
      trl_cnt++;
      if (trl_cnt >= 2) begin
        if (last_ck) begin
          ph = hrcp_pkg::PH_DONE; trl_cnt = 0;
        end else begin
          clear_length();
        end
      end
      return 0;
    end
    if (pend_cr) begin
      pend_cr = 0;
      if (b != "\n" || hex_cnt == 0) begin
        set_fail(hrcp_pkg::FC_CHUNK);
      end else begin
        if (remain == 0) begin
          last_ck = 1; ck_ph = hrcp_pkg::CK_TRAILER;
        end else begin
          ck_ph = hrcp_pkg::CK_PAYLOAD;
        end
        trl_cnt = 0;
      end
      return 0;
    end
    if (b == "\r") begin
      pend_cr = 1;
      return 0;
    end
    v = hex_of(b);
    if (v < 0 || remain[31:28] != 0) begin
      set_fail(hrcp_pkg::FC_CHUNK);
      return 0;
    end
    remain = {remain[27:0], v[3:0]};
    if (hex_cnt < 15) hex_cnt++;
    return 0;
  endfunction

  function automatic hrcp_pkg::result_t decode_step(hrcp_pkg::item_t it);
    hrcp_pkg::result_t r;
    bit vld;
    vld = 0;
    if (ph == hrcp_pkg::PH_STATUS || ph == hrcp_pkg::PH_HEADERS) begin
      if (it.eos) begin
        set_fail(hrcp_pkg::FC_EARLY);
      end else if (pend_cr) begin
        if (it.data == "\n") begin
          pend_cr = 0;
          end_of_line();
        end else begin
          line_byte("\r");
          if (it.data != "\r") begin
            pend_cr = 0;
            line_byte(it.data);
          end
        end
      end else if (it.data == "\r") begin
        pend_cr = 1;
      end else begin
        line_byte(it.data);
      end
    end else if (ph == hrcp_pkg::PH_BODY) begin
      if (!chunked) begin
        if (it.eos) ph = hrcp_pkg::PH_DONE;
        else vld = 1;
      end else if (it.eos) begin
        set_fail(hrcp_pkg::FC_EARLY);
      end else begin
        vld = body_byte(it.data);
      end
    end
    r.content = vld ? it.data : 8'h00;
    r.valid = vld;
    r.phase = ph;
    r.cause = (ph == hrcp_pkg::PH_FAILED) ? cause : hrcp_pkg::FC_NONE;
    return r;
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) byte_q.push_back('{eos: 1'b0, data: s[i]});
  endfunction

  function automatic void push_rand(int n);
    repeat (n) byte_q.push_back('{eos: 1'b0, data: 8'($urandom)});
  endfunction

  function automatic string mixed_case(string s);
    string t;
    t = s;
    foreach (t[i]) if (t[i] >= "a" && t[i] <= "f" && $urandom_range(1)) t[i] = t[i] - 8'd32;
    return t;
  endfunction

  // idling mode from progress: none, sender idle, receiver stall, both light
  function automatic int idle_pct(bit rx_side, int n);
    case ((n / 120) % 4)
      1: return rx_side ? 0 : 58;
      2: return rx_side ? 58 : 0;
      3: return 7;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct(0, sent_cnt)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= byte_q[0].data;
        s_axis_tuser <= byte_q[0].eos;
        void'(byte_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    hrcp_pkg::result_t got, want;
    int nerr;
    if (rst_ni) begin
      nerr = 0;
      cyc_cnt <= cyc_cnt + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        want_q.push_back(decode_step('{eos: s_axis_tuser, data: s_axis_tdata}));
        sent_cnt <= sent_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{content: m_axis_tdata[7:0], valid: m_axis_tuser,
                phase: m_axis_tdata[10:8], cause: m_axis_tdata[13:11]};
        got_cnt <= got_cnt + 1;
        if (got.valid) content_cnt <= content_cnt + 1;
        if (want_q.size() == 0) begin
          $error("unexpected result transfer %p", got);
          nerr++;
        end else begin
          want = want_q.pop_front();
          if (got.content !== want.content) begin
            $error("content_byte: expected %0h actual %0h", want.content, got.content);
            nerr++;
          end
          if (got.valid !== want.valid) begin
            $error("content_valid: expected %0b actual %0b", want.valid, got.valid);
            nerr++;
          end
          if (got.phase !== want.phase) begin
            $error("phase_now: expected %0d actual %0d", want.phase, got.phase);
            nerr++;
          end
          if (got.cause !== want.cause) begin
            $error("fail_cause: expected %0d actual %0d", want.cause, got.cause);
            nerr++;
          end
        end
      end
      if (nerr != 0) err_cnt <= err_cnt + nerr;
    end
  end

  // receiver ready, with one long hold-off so the input side backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && got_cnt >= 200) begin
      hold_done <= 1'b1;
      hold_cnt <= 80;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1, got_cnt));
    end
  end

  initial begin
    int    n, pick;
    string s;
    ph = hrcp_pkg::PH_STATUS; pend_cr = 0; st_pos = 0; ok_seen = 0; chunked = 0;
    last_ck = 0; cause = hrcp_pkg::FC_NONE;
    clear_line();
    clear_length();
    push_text("HT\rTP/1.1 22 200 OK\r\r\n");
    push_text("Host: a:b\r\n");
    push_text("X-Note: chunk ed\r\n");
    push_text("transfer encoding: gzip\r\n");
    push_text(" Transfer-ENCODING :\tCHUNKED \r\n");
    push_text("\r\n");
    push_text("aF\r\n");
    push_rand(175);
    push_text("\r\n");
    while (byte_q.size() < 690) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      s = mixed_case($sformatf("%0h", n));
      if ($urandom_range(3) == 0) s = {"0", s};
      push_text({s, "\r\n"});
      push_rand(n + 2);
    end
    pick = $urandom_range(4);
    case (pick)
      0: begin
        push_text("000\r\n");
        push_rand(2);
      end
      1: push_text("1g");
      2: byte_q.push_back('{eos: 1'b1, data: 8'hff});
      3: push_text("5\rx");
      default: push_text("123456789");
    endcase
    repeat (16) byte_q.push_back('{eos: 1'($urandom), data: 8'($urandom)});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while ((byte_q.size() > 0 || s_axis_tvalid || want_q.size() > 0) && cyc_cnt < 200000)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cyc_cnt >= 200000) begin
      $display("tb_http_response_chunked_parser: errors");
    end else begin
      $display("one chunked response with ending %0d: %0d input transfers, %0d results",
               pick, sent_cnt, got_cnt);
      $display("%0d body bytes passed on, %0d mismatches", content_cnt, err_cnt);
      if (err_cnt == 0 && want_q.size() == 0) begin
        $display("tb_http_response_chunked_parser: clean");
      end else begin
        $display("tb_http_response_chunked_parser: errors");
      end
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hrcp_pkg.sv
rtl/hrcp_front.sv
rtl/hrcp_back.sv
rtl/http_response_chunked_parser.sv
dv/tb_http_response_chunked_parser.sv
